// ----- hdl/mfap_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfap_pkg
// shared types and codes for the max flow block
// ----------------------------------------------------------------------------
package mfap_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_CAP = 2'd0,
    OP_SET_EDGE = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DFS_INIT,
    ST_DFS_RD,
    ST_DFS_CHK,
    ST_MIN_RD,
    ST_MIN_ACC,
    ST_UPD_RDF,
    ST_UPD_RDB,
    ST_UPD_WR,
    ST_DONE
  } state_t;

  localparam int NODES    = 16;
  localparam int CAP_BITS = 16;
  localparam int FLOW_W   = 20;
  localparam int NODE_W   = 4;
  localparam int CAP_W    = 16;

endpackage
`default_nettype wire

// ----- hdl/max_flow_augmenting_paths.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// max_flow_augmenting_paths
// ford-fulkerson max flow with a depth-first path search over a stored graph
// ----------------------------------------------------------------------------
// channel  direction  ports
// input    in         start, busy, in_operation, in_from_node, in_to_node,
//                     in_cap_value
// result   out        out_valid, out_max_flow, out_status
//
// load and edge transactions complete in the idle state and leave busy low.
// a compute holds busy high: a seed state starts each search, each stack visit
// issues a read and then scans its neighbors in turn, and each path found is
// walked for the minimum (read, accumulate) and again for the residual update
// (forward read, backward read, write), all through the single capacity memory.
// source equal to sink gives its result in the cycle after acceptance.
// synchronous active-low reset clears edge bits and control; the capacity
// memory is not cleared. the receiver cannot stall; out_valid lasts one cycle.
// ----------------------------------------------------------------------------
module max_flow_augmenting_paths (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [mfap_pkg::NODE_W-1:0]   in_from_node,
  input  wire logic [mfap_pkg::NODE_W-1:0]   in_to_node,
  input  wire logic [mfap_pkg::CAP_W-1:0]    in_cap_value,
  output logic                               out_valid,
  output logic [mfap_pkg::FLOW_W-1:0]        out_max_flow,
  output logic                               out_status
);
  localparam int NW = mfap_pkg::NODE_W;
  localparam int AW = 2 * NW;
  localparam int RW = mfap_pkg::CAP_BITS + 1;
  localparam int DW = NW + 1;
  localparam logic [RW-1:0] RMAX = {RW{1'b1}};
  localparam logic [mfap_pkg::FLOW_W-1:0] FMAX = {mfap_pkg::FLOW_W{1'b1}};
  localparam int FW = (RW > mfap_pkg::FLOW_W) ? RW + 1 : mfap_pkg::FLOW_W + 1;
  localparam logic [mfap_pkg::NODES-1:0] VIS_ONE = {{(mfap_pkg::NODES-1){1'b0}}, 1'b1};

  mfap_pkg::state_t state_r, state_nxt;

  logic [mfap_pkg::NODES-1:0] edge_r [mfap_pkg::NODES];
  logic [mfap_pkg::NODES-1:0] vis_r;
  logic [NW-1:0]    par_r [mfap_pkg::NODES];
  logic [NW-1:0]    stk_r [mfap_pkg::NODES];
  logic [NW-1:0]    pos_r [mfap_pkg::NODES];
  logic [DW-1:0]    depth_r;
  logic [NW-1:0]    src_r, dst_r, x_r, i_r, v_r, u_r;
  logic [RW-1:0]    push_r;
  logic [mfap_pkg::FLOW_W-1:0] flow_r;
  logic             status_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  mfap_cap_mem #(.AW(AW), .DW(RW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic acc;
  logic in_rng;
  logic [NW-1:0] a_n, b_n;
  logic          top_ok;
  logic [NW-1:0] top_x, top_i;
  logic          i_last;
  logic          hit;
  logic [RW-1:0] push_min;
  logic [RW:0]   back_sum;
  logic [FW-1:0] flow_sum;

  assign acc = start && !busy;
  assign a_n = in_from_node;
  assign b_n = in_to_node;
  assign in_rng = (32'(in_from_node) < mfap_pkg::NODES) &&
                  (32'(in_to_node) < mfap_pkg::NODES);
  assign top_x = stk_r[depth_r[NW-1:0] - NW'(1)];
  assign top_i = pos_r[depth_r[NW-1:0] - NW'(1)];
  assign top_ok = (depth_r != '0);
  assign i_last = (i_r == NW'(mfap_pkg::NODES - 1));
  assign hit = edge_r[x_r][i_r] && (rdata != '0) && !vis_r[i_r];
  assign push_min = (rdata < push_r) ? rdata : push_r;
  assign back_sum = {1'b0, rdata} + {1'b0, push_r};
  assign flow_sum = FW'(flow_r) + FW'(push_min);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfap_pkg::ST_IDLE:
        if (acc && in_operation == mfap_pkg::OP_COMPUTE) begin
          if (in_from_node == in_to_node || !in_rng) state_nxt = mfap_pkg::ST_DONE;
          else state_nxt = mfap_pkg::ST_DFS_INIT;
        end
      mfap_pkg::ST_DFS_INIT: state_nxt = mfap_pkg::ST_DFS_RD;
      mfap_pkg::ST_DFS_RD:
        state_nxt = top_ok ? mfap_pkg::ST_DFS_CHK : mfap_pkg::ST_DONE;
      mfap_pkg::ST_DFS_CHK:
        if (hit && i_r == dst_r) state_nxt = mfap_pkg::ST_MIN_RD;
        else if (hit || i_last) state_nxt = mfap_pkg::ST_DFS_RD;
      mfap_pkg::ST_MIN_RD: state_nxt = mfap_pkg::ST_MIN_ACC;
      mfap_pkg::ST_MIN_ACC:
        state_nxt = (u_r == src_r) ? mfap_pkg::ST_UPD_RDF : mfap_pkg::ST_MIN_RD;
      mfap_pkg::ST_UPD_RDF: state_nxt = mfap_pkg::ST_UPD_RDB;
      mfap_pkg::ST_UPD_RDB: state_nxt = mfap_pkg::ST_UPD_WR;
      mfap_pkg::ST_UPD_WR:
        state_nxt = (u_r == src_r) ? mfap_pkg::ST_DFS_INIT : mfap_pkg::ST_UPD_RDF;
      mfap_pkg::ST_DONE: state_nxt = mfap_pkg::ST_IDLE;
      default: state_nxt = mfap_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state_r != mfap_pkg::ST_IDLE);
    out_valid = (state_r == mfap_pkg::ST_DONE);
    out_max_flow = flow_r;
    out_status = status_r;
    we = 1'b0;
    waddr = {a_n, b_n};
    wdata = RW'(in_cap_value);
    raddr = {x_r, i_r};
    unique case (state_r)
      mfap_pkg::ST_IDLE: we = acc && in_operation == mfap_pkg::OP_LOAD_CAP && in_rng;
      mfap_pkg::ST_DFS_RD: raddr = {top_x, top_i};
      mfap_pkg::ST_DFS_CHK: raddr = {x_r, i_r + NW'(1)};
      mfap_pkg::ST_MIN_RD: raddr = {par_r[v_r], v_r};
      mfap_pkg::ST_UPD_RDF: raddr = {par_r[v_r], v_r};
      mfap_pkg::ST_UPD_RDB: begin
        raddr = {v_r, u_r};
        we = 1'b1;
        waddr = {u_r, v_r};
        wdata = rdata - push_r;
      end
      mfap_pkg::ST_UPD_WR: begin
        we = 1'b1;
        waddr = {v_r, u_r};
        wdata = back_sum[RW] ? RMAX : back_sum[RW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfap_pkg::ST_IDLE;
      for (int k = 0; k < mfap_pkg::NODES; k++) edge_r[k] <= '0;
      vis_r   <= '0;
      depth_r <= '0;
      flow_r  <= '0;
      status_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        mfap_pkg::ST_IDLE:
          if (acc) begin
            if (in_operation == mfap_pkg::OP_SET_EDGE && in_rng)
              edge_r[a_n][b_n] <= 1'b1;
            if (in_operation == mfap_pkg::OP_COMPUTE) begin
              src_r <= a_n;
              dst_r <= b_n;
              flow_r <= '0;
              status_r <= (in_from_node == in_to_node);
            end
          end
        mfap_pkg::ST_DFS_INIT: begin
          vis_r <= VIS_ONE << src_r;
          stk_r[0] <= src_r;
          pos_r[0] <= '0;
          depth_r <= DW'(1);
        end
        mfap_pkg::ST_DFS_RD: begin
          x_r <= top_x;
          i_r <= top_i;
        end
        mfap_pkg::ST_DFS_CHK:
          if (hit) begin
            pos_r[depth_r[NW-1:0] - NW'(1)] <= i_r + NW'(1);
            par_r[i_r] <= x_r;
            v_r <= dst_r;
            push_r <= RMAX;
            if (i_r != dst_r) begin
              vis_r[i_r] <= 1'b1;
              if (depth_r < DW'(mfap_pkg::NODES)) begin
                stk_r[depth_r[NW-1:0]] <= i_r;
                pos_r[depth_r[NW-1:0]] <= '0;
                depth_r <= depth_r + DW'(1);
              end
            end
          end else if (i_last) begin
            depth_r <= depth_r - DW'(1);
          end else begin
            i_r <= i_r + NW'(1);
          end
        mfap_pkg::ST_MIN_RD: u_r <= par_r[v_r];
        mfap_pkg::ST_MIN_ACC: begin
          push_r <= push_min;
          v_r <= (u_r == src_r) ? dst_r : u_r;
          if (u_r == src_r) begin
            if (flow_sum > FW'(FMAX)) flow_r <= FMAX;
            else flow_r <= flow_sum[mfap_pkg::FLOW_W-1:0];
          end
        end
        mfap_pkg::ST_UPD_RDF: u_r <= par_r[v_r];
        mfap_pkg::ST_UPD_WR: v_r <= u_r;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mfap_cap_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfap_cap_mem
// residual capacity memory, one write and one registered read port
// ----------------------------------------------------------------------------
module mfap_cap_mem #(
  parameter int AW = 8,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/mfap_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfap_props
// port-level checks on the max flow block
// ----------------------------------------------------------------------------
module mfap_props (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic [mfap_pkg::FLOW_W-1:0] out_max_flow,
  input wire logic                        out_status
);
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("strobe outside busy");
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe held");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_max_flow == '0) else $error("error with flow");
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy without start");
endmodule

bind max_flow_augmenting_paths mfap_props u_props (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_max_flow(out_max_flow), .out_status(out_status)
);
`default_nettype wire

// ----- sim/mfap_checker.sv -----
// ----------------------------------------------------------------------------
// mfap_checker
// watches the command and result channels of the max flow block, keeps its
// own copy of the residual graph, predicts each compute result and compares
// ----------------------------------------------------------------------------
module mfap_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [mfap_pkg::NODE_W-1:0] in_from_node,
  input  wire logic [mfap_pkg::NODE_W-1:0] in_to_node,
  input  wire logic [mfap_pkg::CAP_W-1:0]  in_cap_value,
  input  wire logic                        out_valid,
  input  wire logic [mfap_pkg::FLOW_W-1:0] out_max_flow,
  input  wire logic                        out_status,
  output int                               mismatches,
  output int                               outstanding
);
  localparam logic [16:0] RESID_MAX = 17'h1FFFF;
  localparam logic [19:0] FLOW_MAX  = 20'hFFFFF;

  typedef struct packed {
    logic [mfap_pkg::FLOW_W-1:0] flow;
    logic                        status;
  } flow_result_t;

  logic [16:0]  resid [16][16];
  logic [15:0]  edges [16];
  logic [3:0]   parent [16];
  flow_result_t flow_q[$];

  function automatic bit find_path(int src, int dst);
    logic [15:0] seen;
    int          stk [16];
    int          pos [16];
    int          depth;
    int          x;
    int          i;
    bit          pushed;
    seen = '0;
    seen[src] = 1'b1;
    stk[0] = src;
    pos[0] = 0;
    depth = 1;
    while (depth > 0) begin
      x = stk[depth-1];
      i = pos[depth-1];
      pushed = 0;
      while (i < 16 && !pushed) begin
        if (edges[x][i] && resid[x][i] != 0 && !seen[i]) begin
          pos[depth-1] = i + 1;
          parent[i] = x[3:0];
          if (i == dst) return 1;
          seen[i] = 1'b1;
          if (depth < 16) begin
            stk[depth] = i;
            pos[depth] = 0;
            depth++;
          end
          pushed = 1;
        end else begin
          i++;
        end
      end
      if (!pushed) depth--;
    end
    return 0;
  endfunction

  function automatic logic [mfap_pkg::FLOW_W-1:0] predict_flow(int src, int dst);
    logic [19:0] total;
    logic [16:0] push;
    logic [17:0] back;
    logic [20:0] sum;
    int          v;
    int          u;
    total = '0;
    while (find_path(src, dst)) begin
      push = RESID_MAX;
      v = dst;
      while (v != src) begin
        u = parent[v];
        if (resid[u][v] < push) push = resid[u][v];
        v = u;
      end
      v = dst;
      while (v != src) begin
        u = parent[v];
        back = {1'b0, resid[v][u]} + {1'b0, push};
        resid[u][v] = resid[u][v] - push;
        resid[v][u] = back > {1'b0, RESID_MAX} ? RESID_MAX : back[16:0];
        v = u;
      end
      sum = {1'b0, total} + {4'd0, push};
      total = sum > {1'b0, FLOW_MAX} ? FLOW_MAX : sum[19:0];
    end
    return total;
  endfunction

  always @(posedge clk) begin
    flow_result_t want;
    if (!rst_n) begin
      for (int n = 0; n < 16; n++) edges[n] <= '0;
      flow_q.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (flow_q.size() == 0) begin
          $error("result transaction with nothing expected: out_max_flow %0d status %0d",
                 out_max_flow, out_status);
          mismatches <= mismatches + 1;
        end else begin
          want = flow_q.pop_front();
          if (out_max_flow !== want.flow || out_status !== want.status)
            mismatches <= mismatches + 1;
          if (out_max_flow !== want.flow)
            $error("out_max_flow expected %0d actual %0d", want.flow, out_max_flow);
          if (out_status !== want.status)
            $error("status expected %0d actual %0d", want.status, out_status);
        end
      end
      if (start && !busy) begin
        case (mfap_pkg::op_t'(in_operation))
          mfap_pkg::OP_LOAD_CAP: resid[in_from_node][in_to_node] = {1'b0, in_cap_value};
          mfap_pkg::OP_SET_EDGE: edges[in_from_node][in_to_node] <= 1'b1;
          mfap_pkg::OP_COMPUTE: begin
            if (in_from_node == in_to_node) begin
              want.flow = '0;
              want.status = 1'b1;
            end else begin
              want.flow = predict_flow(in_from_node, in_to_node);
              want.status = 1'b0;
            end
            flow_q.insert(flow_q.size(), want);
          end
          default: ;
        endcase
      end
      outstanding <= flow_q.size();
    end
  end
endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives capacity loads, edge bits and compute commands into the max flow
// block with varying sender gaps; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb;
  localparam int CYCLE_LIMIT = 20000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = mfap_pkg::OP_NONE;
  logic [3:0]  in_from_node = '0;
  logic [3:0]  in_to_node = '0;
  logic [15:0] in_cap_value = '0;
  logic        out_valid;
  logic [19:0] out_max_flow;
  logic        out_status;
  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  int          sent = 0;
  int          idle_pct = 0;
  bit          loaded [256];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  max_flow_augmenting_paths dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_from_node, .in_to_node,
    .in_cap_value, .out_valid, .out_max_flow, .out_status
  );

  mfap_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_operation, .in_from_node, .in_to_node,
    .in_cap_value, .out_valid, .out_max_flow, .out_status, .mismatches, .outstanding
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("max_flow_augmenting_paths verification failed");
      $finish;
    end
  end

  task automatic send(mfap_pkg::op_t op, int a, int b, logic [15:0] cap);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_from_node <= a[3:0];
    in_to_node <= b[3:0];
    in_cap_value <= cap;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == mfap_pkg::OP_LOAD_CAP) loaded[a*16+b] = 1'b1;
    sent++;
  endtask

  function automatic logic [15:0] rand_cap();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 16'($urandom_range(65535));
    return 16'($urandom_range(0, 7));
  endfunction

  task automatic link_nodes(int a, int b);
    if (!loaded[a*16+b]) send(mfap_pkg::OP_LOAD_CAP, a, b, rand_cap());
    if (!loaded[b*16+a]) send(mfap_pkg::OP_LOAD_CAP, b, a, rand_cap());
    send(mfap_pkg::OP_SET_EDGE, a, b, 16'($urandom));
  endtask

  initial begin
    int n;
    int r;
    int a;
    int b;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // source equals sink, unused code, empty graph
    send(mfap_pkg::OP_COMPUTE, 3, 3, 16'hFFFF);
    send(mfap_pkg::OP_NONE, 15, 15, 16'hFFFF);
    send(mfap_pkg::OP_COMPUTE, 0, 1, 16'h0000);
    // full-scale path with reverse residual saturation
    send(mfap_pkg::OP_LOAD_CAP, 0, 1, 16'hFFFF);
    send(mfap_pkg::OP_LOAD_CAP, 1, 0, 16'h0000);
    send(mfap_pkg::OP_LOAD_CAP, 1, 2, 16'hFFFF);
    send(mfap_pkg::OP_LOAD_CAP, 2, 1, 16'hFFFF);
    send(mfap_pkg::OP_SET_EDGE, 0, 1, 16'h0000);
    send(mfap_pkg::OP_SET_EDGE, 1, 2, 16'hFFFF);
    send(mfap_pkg::OP_COMPUTE, 0, 2, 16'h0000);
    send(mfap_pkg::OP_COMPUTE, 0, 2, 16'hFFFF);
    send(mfap_pkg::OP_LOAD_CAP, 0, 1, 16'hFFFF);
    send(mfap_pkg::OP_LOAD_CAP, 1, 2, 16'hFFFF);
    send(mfap_pkg::OP_COMPUTE, 0, 2, 16'h0000);
    send(mfap_pkg::OP_COMPUTE, 2, 0, 16'h0000);
    // zero capacity edge at the top node
    send(mfap_pkg::OP_LOAD_CAP, 15, 14, 16'h0000);
    send(mfap_pkg::OP_LOAD_CAP, 14, 15, 16'h0005);
    send(mfap_pkg::OP_SET_EDGE, 15, 14, 16'h0000);
    send(mfap_pkg::OP_SET_EDGE, 14, 15, 16'h0000);
    send(mfap_pkg::OP_COMPUTE, 15, 14, 16'h0000);
    send(mfap_pkg::OP_COMPUTE, 14, 15, 16'hFFFF);

    while (sent < 1750) begin
      case ((sent * 4) / 1750)
        0: idle_pct = 0;
        1: idle_pct = 69;
        2: idle_pct = 18;
        default: idle_pct = $urandom_range(1) ? 0 : 69;
      endcase
      n = $urandom_range(2, 12);
      repeat (n) begin
        r = $urandom_range(99);
        a = $urandom_range(15);
        b = $urandom_range(15);
        if (r < 45) send(mfap_pkg::OP_LOAD_CAP, a, b, rand_cap());
        else if (r < 90) link_nodes(a, b);
        else send(mfap_pkg::OP_NONE, a, b, 16'($urandom));
      end
      a = $urandom_range(15);
      b = ($urandom_range(9) == 0) ? a : $urandom_range(15);
      send(mfap_pkg::OP_COMPUTE, a, b, 16'($urandom));
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("max_flow_augmenting_paths verification clean");
    else
      $display("max_flow_augmenting_paths verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/mfap_pkg.sv
hdl/mfap_cap_mem.sv
hdl/max_flow_augmenting_paths.sv
hdl/mfap_checker.sv
sim/mfap_checker.sv
sim/tb.sv
